// ===== rtl/core/irpdt_pkg.sv =====
package irpdt_pkg;

    localparam int FRAME_BITS = 32;
    localparam int BITS_W     = $clog2(FRAME_BITS + 1);
    localparam int TICK_W     = 16;
    localparam int CODE_W     = 32;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HDR_MARK  = 3'd1,
        PH_HDR_SPACE = 3'd2,
        PH_BIT_MARK  = 3'd3,
        PH_BIT_SPACE = 3'd4,
        PH_TRAIL     = 3'd5
    } t_phase;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SEND = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HDR_MARK   = 3'd0,
        REG_HDR_SPACE  = 3'd1,
        REG_ONE_MARK   = 3'd2,
        REG_ONE_SPACE  = 3'd3,
        REG_ZERO_MARK  = 3'd4,
        REG_ZERO_SPACE = 3'd5,
        REG_TRAIL_MARK = 3'd6
    } t_reg_idx;

    localparam logic [TICK_W-1:0] RST_HDR_MARK   = 16'd9039;
    localparam logic [TICK_W-1:0] RST_HDR_SPACE  = 16'd4406;
    localparam logic [TICK_W-1:0] RST_ONE_MARK   = 16'd639;
    localparam logic [TICK_W-1:0] RST_ONE_SPACE  = 16'd1601;
    localparam logic [TICK_W-1:0] RST_ZERO_MARK  = 16'd639;
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE = 16'd486;
    localparam logic [TICK_W-1:0] RST_TRAIL_MARK = 16'd641;

    typedef struct packed {
        logic [TICK_W-1:0] hdr_mark;
        logic [TICK_W-1:0] hdr_space;
        logic [TICK_W-1:0] bit1_mark;
        logic [TICK_W-1:0] bit1_space;
        logic [TICK_W-1:0] bit0_mark;
        logic [TICK_W-1:0] bit0_space;
        logic [TICK_W-1:0] trail_mark;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic send_rejected;
        logic frame_done;
    } t_result;

endpackage

// ===== rtl/core/ir_pulse_distance_transmitter_core.sv =====
// Baseband pulse-distance IR frame transmitter. A send transaction (opcode 1) starts a frame
// of header mark, header space, one mark/space pair per code bit (LSB first) and a trailing
// mark; a tick transaction (opcode 0) advances it by one microsecond. Every input transaction
// gives exactly one result transaction with the line level and status after it. One input
// transaction is taken per clock unless input stall is high; its result is registered. A
// two-entry output stage (result register plus skid register) keeps input stall registered,
// so input stall rises only when two results are waiting. Duration registers take one write
// per cycle (ready is always high) and should be written only while no frame is in progress.
module ir_pulse_distance_transmitter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_opcode,
    input  logic [irpdt_pkg::CODE_W-1:0]     i_code_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_line_level,
    output logic                             o_busy_res,
    output logic                             o_send_rejected,
    output logic                             o_frame_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irpdt_pkg::TICK_W-1:0]     i_cfg_data
);
    import irpdt_pkg::*;

    t_cfg     cfg;
    t_result  res;
    logic     accept;
    logic     out_take;

    logic     r_out_valid;
    t_result  r_out;
    logic     r_skid_valid;
    t_result  r_skid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;

    irpdt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    irpdt_frame_seq u_frame_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_code_word (i_code_word),
        .i_cfg       (cfg),
        .o_result    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (accept) begin
                if (r_out_valid && !out_take) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_level    = r_out.line_level;
    assign o_busy_res      = r_out.busy_res;
    assign o_send_rejected = r_out.send_rejected;
    assign o_frame_done    = r_out.frame_done;

endmodule

// ===== rtl/core/irpdt_cfg_regs.sv =====
module irpdt_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [irpdt_pkg::TICK_W-1:0]     i_wr_data,
    output irpdt_pkg::t_cfg                  o_cfg
);
    import irpdt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_mark   <= RST_HDR_MARK;
            r_cfg.hdr_space  <= RST_HDR_SPACE;
            r_cfg.bit1_mark  <= RST_ONE_MARK;
            r_cfg.bit1_space <= RST_ONE_SPACE;
            r_cfg.bit0_mark  <= RST_ZERO_MARK;
            r_cfg.bit0_space <= RST_ZERO_SPACE;
            r_cfg.trail_mark <= RST_TRAIL_MARK;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_HDR_MARK:   r_cfg.hdr_mark   <= i_wr_data;
                REG_HDR_SPACE:  r_cfg.hdr_space  <= i_wr_data;
                REG_ONE_MARK:   r_cfg.bit1_mark  <= i_wr_data;
                REG_ONE_SPACE:  r_cfg.bit1_space <= i_wr_data;
                REG_ZERO_MARK:  r_cfg.bit0_mark  <= i_wr_data;
                REG_ZERO_SPACE: r_cfg.bit0_space <= i_wr_data;
                REG_TRAIL_MARK: r_cfg.trail_mark <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/irpdt_frame_seq.sv =====
module irpdt_frame_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_opcode,
    input  logic [irpdt_pkg::CODE_W-1:0]  i_code_word,
    input  irpdt_pkg::t_cfg               i_cfg,
    output irpdt_pkg::t_result            o_result
);
    import irpdt_pkg::*;

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_ticks_left, n_ticks_left;
    logic [CODE_W-1:0]   r_payload_shift, n_payload_shift;
    logic [BITS_W-1:0]   r_bits_left, n_bits_left;
    logic                r_level, n_level;

    logic                is_send;
    logic                is_tick;
    logic                seg_end;
    logic                cur_one;
    logic                nxt_one;
    logic [BITS_W-1:0]   bits_dec;

    assign is_send  = i_accept && (i_opcode == OP_SEND);
    assign is_tick  = i_accept && (i_opcode == OP_TICK);
    assign seg_end  = (r_phase != PH_IDLE) && (r_ticks_left <= TICK_W'(1));
    assign cur_one  = r_payload_shift[0];
    assign nxt_one  = r_payload_shift[1];
    assign bits_dec = r_bits_left - BITS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_ticks_left    <= '0;
            r_payload_shift <= '0;
            r_bits_left     <= '0;
            r_level         <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_ticks_left    <= n_ticks_left;
            r_payload_shift <= n_payload_shift;
            r_bits_left     <= n_bits_left;
            r_level         <= n_level;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_ticks_left    = r_ticks_left;
        n_payload_shift = r_payload_shift;
        n_bits_left     = r_bits_left;
        n_level         = r_level;
        if (is_send) begin
            if (r_phase == PH_IDLE) begin
                n_payload_shift = i_code_word;
                n_bits_left     = BITS_W'(FRAME_BITS);
                n_phase         = PH_HDR_MARK;
                n_ticks_left    = i_cfg.hdr_mark;
                n_level         = 1'b1;
            end
        end else if (is_tick && (r_phase != PH_IDLE)) begin
            if (!seg_end) begin
                n_ticks_left = r_ticks_left - TICK_W'(1);
            end else begin
                case (r_phase)
                    PH_HDR_MARK: begin
                        n_phase      = PH_HDR_SPACE;
                        n_ticks_left = i_cfg.hdr_space;
                        n_level      = 1'b0;
                    end
                    PH_HDR_SPACE: begin
                        n_phase      = PH_BIT_MARK;
                        n_ticks_left = cur_one ? i_cfg.bit1_mark : i_cfg.bit0_mark;
                        n_level      = 1'b1;
                    end
                    PH_BIT_MARK: begin
                        n_phase      = PH_BIT_SPACE;
                        n_ticks_left = cur_one ? i_cfg.bit1_space : i_cfg.bit0_space;
                        n_level      = 1'b0;
                    end
                    PH_BIT_SPACE: begin
                        n_payload_shift = r_payload_shift >> 1;
                        n_bits_left     = bits_dec;
                        n_level         = 1'b1;
                        if (bits_dec == '0) begin
                            n_phase      = PH_TRAIL;
                            n_ticks_left = i_cfg.trail_mark;
                        end else begin
                            n_phase      = PH_BIT_MARK;
                            n_ticks_left = nxt_one ? i_cfg.bit1_mark : i_cfg.bit0_mark;
                        end
                    end
                    default: begin
                        n_phase      = PH_IDLE;
                        n_ticks_left = '0;
                        n_level      = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.line_level    = n_level;
        o_result.busy_res      = (n_phase != PH_IDLE);
        o_result.send_rejected = is_send && (r_phase != PH_IDLE);
        o_result.frame_done    = is_tick && seg_end
                                 && !(r_phase inside {PH_HDR_MARK, PH_HDR_SPACE,
                                                      PH_BIT_MARK, PH_BIT_SPACE});
    end

endmodule
